### sv/uer_pkg.sv
// shared types and constants of the ultrasonic echo ranger
package uer_pkg;

    // echo tick counter width
    localparam int COUNT_W = 16;
    localparam int TRIG_W  = 8;
    localparam int SCALE_W = 22;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = COUNT_W + SCALE_W;
    localparam int DIST_W  = PROD_W - FRAC_W;
    localparam int NUM_DIGITS = 5;
    localparam int DIGIT_W    = 4;
    localparam int DIGITS_W   = NUM_DIGITS * DIGIT_W;

    // divide by ten as multiply by reciprocal, exact for any DIST_W-bit value
    localparam int DIV_SHIFT = DIST_W + 4;
    localparam longint unsigned DIV_MULT_L = ((64'd1 << DIV_SHIFT) + 64'd9) / 64'd10;
    localparam logic [DIST_W:0] DIV_MULT = DIV_MULT_L[DIST_W:0];
    localparam int DIV_PROD_W = 2 * DIST_W + 1;
    localparam int QUOT_W     = DIV_PROD_W - DIV_SHIFT;

    // register reset values
    localparam logic [TRIG_W-1:0]  TRIGGER_TICKS_RST = 8'd11;
    localparam logic [SCALE_W-1:0] SCALE_Q16_RST     = 22'd1219478;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_TRIGGER_TICKS = 1'b0,
        REG_SCALE_Q16     = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic trigger;
        logic busy;
        logic done;
        logic timeout;
    } t_flags;

    typedef struct packed {
        t_flags             flags;
        logic [COUNT_W-1:0] count;
    } t_ctrl_out;

    // one pipeline slot of the distance and digit stages
    typedef struct packed {
        t_flags              flags;
        logic [DIST_W-1:0]   value;
        logic [DIGITS_W-1:0] digits;
    } t_stage;

endpackage

### sv/uer_ctrl.sv
// measurement sequencer: trigger, echo wait and echo tick count
module uer_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_start_req,
    input  logic                       i_echo_level,
    input  logic [uer_pkg::TRIG_W-1:0] i_trigger_ticks,
    output logic                       o_valid,
    input  logic                       i_ready,
    output uer_pkg::t_ctrl_out         o_data
);
    import uer_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_TRIG  = 2'd1,
        PH_WAIT  = 2'd2,
        PH_COUNT = 2'd3
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [TRIG_W-1:0]  r_trig_left, n_trig_left;
    logic               r_ovf, n_ovf;
    logic               n_done;
    logic               r_valid;
    t_ctrl_out          r_data;
    logic               w_accept;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_valid;
    assign o_data   = r_data;

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_trig_left = r_trig_left;
        n_ovf       = r_ovf;
        n_done      = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    // a zero trigger length behaves as one tick
                    n_trig_left = (i_trigger_ticks == '0) ? '0 : i_trigger_ticks - 1'b1;
                    n_count     = '0;
                    n_ovf       = 1'b0;
                    n_phase     = PH_TRIG;
                end
            end
            PH_TRIG: begin
                if (r_trig_left == '0) begin
                    n_phase = PH_WAIT;
                end else begin
                    n_trig_left = r_trig_left - 1'b1;
                end
            end
            PH_WAIT: begin
                if (i_echo_level) begin
                    n_count = COUNT_W'(1);
                    n_phase = PH_COUNT;
                end
            end
            PH_COUNT: begin
                if (i_echo_level) begin
                    n_count = r_count + 1'b1;
                    if (r_count == '1) begin
                        // counter wrapped: timeout, count reads zero
                        n_ovf   = 1'b1;
                        n_done  = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end else begin
                    n_done  = 1'b1;
                    n_phase = PH_IDLE;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_trig_left <= '0;
            r_ovf       <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase     <= n_phase;
                r_count     <= n_count;
                r_trig_left <= n_trig_left;
                r_ovf       <= n_ovf;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
        if (w_accept) begin
            r_data.flags.trigger <= (n_phase == PH_TRIG);
            r_data.flags.busy    <= (n_phase != PH_IDLE);
            r_data.flags.done    <= n_done;
            r_data.flags.timeout <= n_ovf;
            r_data.count         <= n_count;
        end
    end

    // count is cleared for the whole trigger pulse
    a_trig_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_TRIG |-> r_count == '0)
        else $error("count not clear during trigger");

    // overflow can only be flagged once the measurement has ended
    a_ovf_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_phase == PH_IDLE)
        else $error("overflow flag set while measuring");

    // a finishing transaction always leaves the sequencer idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && n_done |=> r_phase == PH_IDLE)
        else $error("done without return to idle");

endmodule

### sv/uer_mult.sv
// distance stage: tick count times q16 scale, fraction dropped
module uer_mult (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  uer_pkg::t_ctrl_out          i_data,
    input  logic [uer_pkg::SCALE_W-1:0] i_scale_q16,
    output logic                        o_valid,
    input  logic                        i_ready,
    output uer_pkg::t_stage             o_data
);
    import uer_pkg::*;

    logic              r_valid;
    t_stage            r_data;
    logic [PROD_W-1:0] w_prod;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign w_prod  = PROD_W'(i_data.count) * PROD_W'(i_scale_q16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data.flags  <= i_data.flags;
            r_data.value  <= w_prod[PROD_W-1:FRAC_W];
            r_data.digits <= '0;
        end
    end

endmodule

### sv/uer_digit.sv
// one decimal digit per stage: value / 10 by reciprocal, remainder shifted in
module uer_digit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  uer_pkg::t_stage i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output uer_pkg::t_stage o_data
);
    import uer_pkg::*;

    logic                  r_valid;
    t_stage                r_data;
    logic [DIV_PROD_W-1:0] w_prod;
    logic [QUOT_W-1:0]     w_quot;
    logic [DIGIT_W-1:0]    w_times10;
    logic [DIGIT_W-1:0]    w_digit;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    assign w_prod    = DIV_PROD_W'(i_data.value) * DIV_PROD_W'(DIV_MULT);
    assign w_quot    = w_prod[DIV_PROD_W-1:DIV_SHIFT];
    // only the low nibble of quot*10 is needed for the remainder
    assign w_times10 = {w_quot[0], 3'b000} + {w_quot[2:0], 1'b0};
    assign w_digit   = i_data.value[DIGIT_W-1:0] - w_times10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data.flags  <= i_data.flags;
            r_data.value  <= DIST_W'(w_quot);
            // lowest digit ends up in the bottom nibble after all stages
            r_data.digits <= {w_digit, i_data.digits[DIGITS_W-1:DIGIT_W]};
        end
    end

endmodule

### sv/ultrasonic_echo_ranger.sv
// top level of the ultrasonic echo ranger: config port, pipeline and result register
//
//  channel   direction  handshake            payload
//  tick in   input      i_valid / o_ready    i_start_req, i_echo_level
//  result    output     o_valid / i_ready    o_trigger_level, o_busy_res, o_done_res,
//                                            o_timeout, o_digit_* (five digits)
//  config    input      psel/penable/pwrite  paddr, pwdata, prdata, pready
//
//  one tick transaction accepted per cycle while o_ready is high, one result per tick, in order
//  registered stages in order: sequencer register, multiply stage, five digit stages,
//  result register; the longest path is one 22x23 reciprocal multiply
//  every stage holds while it is full and the stage after it is not ready, bubbles collapse
//  reset (synchronous, i_rst_n low) returns the sequencer to idle, clears the digits
//  and the sequencer overflow flag, and restores the register defaults; result flags are not reset
module ultrasonic_echo_ranger (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // tick transactions
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_start_req,
    input  logic                        i_echo_level,
    // result transactions
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_trigger_level,
    output logic                        o_busy_res,
    output logic                        o_done_res,
    output logic                        o_timeout,
    output logic [uer_pkg::DIGIT_W-1:0] o_digit_tens,
    output logic [uer_pkg::DIGIT_W-1:0] o_digit_units,
    output logic [uer_pkg::DIGIT_W-1:0] o_digit_tenths,
    output logic [uer_pkg::DIGIT_W-1:0] o_digit_hundredths,
    output logic [uer_pkg::DIGIT_W-1:0] o_digit_thousandths,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import uer_pkg::*;

    // configuration registers
    logic [TRIG_W-1:0]  r_trigger_ticks;
    logic [SCALE_W-1:0] r_scale_q16;
    logic               w_cfg_write;
    t_reg_idx           w_reg_idx;

    assign pready      = 1'b1;
    assign w_reg_idx   = t_reg_idx'(paddr[2]);
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_ticks <= TRIGGER_TICKS_RST;
            r_scale_q16     <= SCALE_Q16_RST;
        end else if (w_cfg_write) begin
            unique case (w_reg_idx)
                REG_TRIGGER_TICKS: r_trigger_ticks <= pwdata[TRIG_W-1:0];
                REG_SCALE_Q16:     r_scale_q16     <= pwdata[SCALE_W-1:0];
                default:           r_trigger_ticks <= r_trigger_ticks;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (w_reg_idx)
            REG_TRIGGER_TICKS: prdata = 32'(r_trigger_ticks);
            REG_SCALE_Q16:     prdata = 32'(r_scale_q16);
            default:           prdata = '0;
        endcase
    end

    // sequencer: phase, trigger length, echo counter
    logic      w_ctrl_valid, w_ctrl_ready;
    t_ctrl_out w_ctrl_data;

    uer_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_start_req     (i_start_req),
        .i_echo_level    (i_echo_level),
        .i_trigger_ticks (r_trigger_ticks),
        .o_valid         (w_ctrl_valid),
        .i_ready         (w_ctrl_ready),
        .o_data          (w_ctrl_data)
    );

    // distance in thousandths of a cm
    logic   w_stg_valid [NUM_DIGITS+1];
    logic   w_stg_ready [NUM_DIGITS+1];
    t_stage w_stg_data  [NUM_DIGITS+1];

    uer_mult u_mult (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_ctrl_valid),
        .o_ready     (w_ctrl_ready),
        .i_data      (w_ctrl_data),
        .i_scale_q16 (r_scale_q16),
        .o_valid     (w_stg_valid[0]),
        .i_ready     (w_stg_ready[0]),
        .o_data      (w_stg_data[0])
    );

    // one digit per stage, thousandths first
    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_digit
        uer_digit u_digit (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_stg_valid[g]),
            .o_ready (w_stg_ready[g]),
            .i_data  (w_stg_data[g]),
            .o_valid (w_stg_valid[g+1]),
            .i_ready (w_stg_ready[g+1]),
            .o_data  (w_stg_data[g+1])
        );
    end

    // result register; the digit field doubles as the stored last result
    logic                r_out_valid;
    t_flags              r_out_flags;
    logic [DIGITS_W-1:0] r_digits;
    logic                w_load;
    t_stage              w_last;

    assign w_last                  = w_stg_data[NUM_DIGITS];
    assign w_stg_ready[NUM_DIGITS] = !r_out_valid || i_ready;
    assign w_load                  = w_stg_valid[NUM_DIGITS] && w_stg_ready[NUM_DIGITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_digits    <= '0;
        end else begin
            if (w_stg_ready[NUM_DIGITS]) begin
                r_out_valid <= w_stg_valid[NUM_DIGITS];
            end
            // digits change only when a measurement completes
            if (w_load && w_last.flags.done) begin
                r_digits <= w_last.digits;
            end
        end
        if (w_load) begin
            r_out_flags <= w_last.flags;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_trigger_level     = r_out_flags.trigger;
    assign o_busy_res          = r_out_flags.busy;
    assign o_done_res          = r_out_flags.done;
    assign o_timeout           = r_out_flags.timeout;
    assign o_digit_thousandths = r_digits[0*DIGIT_W +: DIGIT_W];
    assign o_digit_hundredths  = r_digits[1*DIGIT_W +: DIGIT_W];
    assign o_digit_tenths      = r_digits[2*DIGIT_W +: DIGIT_W];
    assign o_digit_units       = r_digits[3*DIGIT_W +: DIGIT_W];
    assign o_digit_tens        = r_digits[4*DIGIT_W +: DIGIT_W];

    // a timed out measurement reports zero distance
    a_timeout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_flags.done && r_out_flags.timeout |-> r_digits == '0)
        else $error("timeout with nonzero distance");

    // a completed result is never shown while still busy or triggering
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_flags.done |-> !r_out_flags.busy && !r_out_flags.trigger)
        else $error("done while busy");

    // every stored digit is a decimal digit
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_digit_tens <= 4'd9 && o_digit_units <= 4'd9 && o_digit_tenths <= 4'd9
        && o_digit_hundredths <= 4'd9 && o_digit_thousandths <= 4'd9)
        else $error("digit out of range");

    // digits hold across results that do not complete a measurement
    a_digits_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && !w_last.flags.done |=> $stable(r_digits))
        else $error("digits changed without a completed measurement");

endmodule
